@@ rtl/pee_pkg.sv @@
`timescale 1ns / 1ps

package pee_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADOP   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;

  localparam logic [31:0] EMPTY_POP = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_BAD
  } sym_cls_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               overflow_seen;
    logic               underflow_seen;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic push_dig;
    logic rd;
    logic eval;
    logic push_res;
    logic emit;
  } pee_cmd_t;

  typedef struct packed {
    sym_cls_t cls;
    logic     last;
    logic     bad_mode;
    logic     rhs_zero;
    logic     div_done;
    logic     out_full;
  } pee_sts_t;

  function automatic sym_cls_t sym_class(input logic [7:0] sym);
    sym_cls_t cls;
    if (sym >= CH_0 && sym <= CH_9) begin
      cls = CLS_DIGIT;
    end else if (sym == CH_ADD) begin
      cls = CLS_ADD;
    end else if (sym == CH_SUB) begin
      cls = CLS_SUB;
    end else if (sym == CH_MUL) begin
      cls = CLS_MUL;
    end else if (sym == CH_DIV) begin
      cls = CLS_DIV;
    end else begin
      cls = CLS_BAD;
    end
    return cls;
  endfunction

endpackage

@@ rtl/pee_div.sv @@
`timescale 1ns / 1ps

module pee_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  step_r;
  logic        neg_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] mb_r;

  logic        na;
  logic        nb;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign na = dividend[31];
  assign nb = divisor[31];
  assign ma = na ? (32'd0 - dividend) : dividend;
  assign mb = nb ? (32'd0 - divisor) : divisor;

  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // one restoring step per cycle, quotient bits shift in from the right
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= ma;
      mb_r  <= mb;
      neg_r <= na ^ nb;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule

@@ rtl/pee_dpath.sv @@
`timescale 1ns / 1ps

module pee_dpath #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pee_pkg::in_item_t   in_data,
  input  pee_pkg::pee_cmd_t   cmd,
  output pee_pkg::pee_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output pee_pkg::out_item_t  out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] stk_mem [STACK_DEPTH];

  logic [7:0]          sym_r;
  logic                last_r;
  logic [CW-1:0]       cnt_r;
  logic [1:0]          st_r;
  logic                ovf_r;
  logic                unf_r;
  logic [31:0]         rd_a_r;
  logic [31:0]         rd_b_r;
  logic [31:0]         res_r;
  logic                out_valid_r;
  pee_pkg::out_item_t  out_r;

  pee_pkg::sym_cls_t   cls;
  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       cnt_m2;
  logic [AW-1:0]       addr_a;
  logic [AW-1:0]       addr_b;
  logic                full;
  logic                has1;
  logic                has2;
  logic [31:0]         rhs;
  logic [31:0]         lhs;
  logic [31:0]         prod;
  logic [7:0]          dig_val;
  logic                do_push;
  logic [31:0]         push_val;
  logic                div_start;
  logic                div_done;
  logic [31:0]         div_q;

  assign cls     = pee_pkg::sym_class(sym_r);
  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign addr_a  = cnt_m1[AW-1:0];
  assign addr_b  = cnt_m2[AW-1:0];
  assign full    = (cnt_r == CW'(STACK_DEPTH));
  assign has1    = (cnt_r != '0);
  assign has2    = (cnt_r >= CW'(2));
  assign rhs     = has1 ? rd_a_r : pee_pkg::EMPTY_POP;
  assign lhs     = has2 ? rd_b_r : pee_pkg::EMPTY_POP;
  assign prod    = lhs * rhs;
  assign dig_val = sym_r - pee_pkg::CH_0;
  assign do_push = cmd.push_dig || cmd.push_res;
  assign push_val = cmd.push_dig ? {24'd0, dig_val} : res_r;

  assign div_start = cmd.eval && (cls == pee_pkg::CLS_DIV) && (rhs != '0);

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (rhs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      st_r        <= pee_pkg::ST_OK;
      ovf_r       <= 1'b0;
      unf_r       <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (do_push) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end

      if (cmd.eval) begin
        cnt_r <= has2 ? cnt_m2 : '0;
        if (!has2) begin
          unf_r <= 1'b1;
        end
        if (cls == pee_pkg::CLS_BAD) begin
          st_r <= pee_pkg::ST_BADOP;
        end else if (cls == pee_pkg::CLS_DIV && rhs == '0 && st_r == pee_pkg::ST_OK) begin
          st_r <= pee_pkg::ST_DIVZERO;
        end
      end

      // result leaves: start the next expression from an empty stack
      if (cmd.emit) begin
        cnt_r <= '0;
        st_r  <= pee_pkg::ST_OK;
        ovf_r <= 1'b0;
        unf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_r  <= in_data.symbol;
      last_r <= in_data.last_symbol;
    end
    if (do_push && !full) begin
      stk_mem[cnt_r[AW-1:0]] <= push_val;
    end
    if (cmd.rd) begin
      rd_a_r <= stk_mem[addr_a];
      rd_b_r <= stk_mem[addr_b];
    end
    if (cmd.eval) begin
      case (cls)
        pee_pkg::CLS_ADD: res_r <= lhs + rhs;
        pee_pkg::CLS_SUB: res_r <= lhs - rhs;
        pee_pkg::CLS_MUL: res_r <= prod;
        default:          res_r <= '0;
      endcase
    end else if (div_done) begin
      res_r <= div_q;
    end
    if (cmd.emit) begin
      out_r.value          <= has1 ? rd_a_r : pee_pkg::EMPTY_POP;
      out_r.status         <= st_r;
      out_r.overflow_seen  <= ovf_r;
      out_r.underflow_seen <= unf_r || !has1;
    end
  end

  assign sts.cls      = cls;
  assign sts.last     = last_r;
  assign sts.bad_mode = (st_r == pee_pkg::ST_BADOP);
  assign sts.rhs_zero = (rhs == '0);
  assign sts.div_done = div_done;
  assign sts.out_full = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/pee_ctrl.sv @@
`timescale 1ns / 1ps

module pee_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pee_pkg::pee_sts_t  sts,
  output pee_pkg::pee_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_DIV_WAIT,
    S_PUSH,
    S_FIN_RD,
    S_FIN_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  state_t after_item;

  assign after_item = sts.last ? S_FIN_RD : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bad_mode) begin
          state_nxt = after_item;
        end else if (sts.cls == pee_pkg::CLS_DIGIT) begin
          cmd.push_dig = 1'b1;
          state_nxt    = after_item;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.cls == pee_pkg::CLS_BAD) begin
          state_nxt = after_item;
        end else if (sts.cls == pee_pkg::CLS_DIV && !sts.rhs_zero) begin
          state_nxt = S_DIV_WAIT;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt    = after_item;
      end
      S_FIN_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIN_EMIT;
      end
      S_FIN_EMIT: begin
        // hold until the previous result has gone
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
`timescale 1ns / 1ps

// channel   ports                          beat
// input     in_valid  in_stall  in_data    one character, last_symbol marks the end
// result    out_valid out_stall out_data   value, status and flags of one expression
//
// Digit: decode and push. Add, subtract, multiply: decode, stack read, evaluate, push.
// Divide by a non-zero value waits on the one-bit-per-cycle 32-step divider before the push.
// The last character adds a final stack read and the result beat.
// Reset clears the stack count and flags only; the stack memory is never cleared.
// A stalled result register holds the block in its final step; earlier beats still go in.

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pee_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pee_pkg::out_item_t  out_data
);

  pee_pkg::pee_cmd_t cmd;
  pee_pkg::pee_sts_t sts;

  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pee_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second beat before finishing the first");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_full)
    else $error("result overwritten before it was taken");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push_dig, cmd.push_res, cmd.rd, cmd.eval, cmd.emit}))
    else $error("datapath commands overlap");

  a_eval_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> $past(cmd.rd))
    else $error("operands evaluated without a stack read");

endmodule
